[src/esp_pkg.sv]
// Shared widths, register indexes and the job header type for the set packing core.
package esp_pkg;

  localparam int MASK_W  = 64;  // set_mask field width
  localparam int COUNT_W = 5;   // set_count register width
  localparam int CODE_W  = 17;  // subset code and range register width
  localparam int BEST_W  = 5;   // best_packing field width
  localparam int CFG_W   = 17;  // configuration write data width
  localparam int CIDX_W  = 2;   // configuration register index width

  typedef enum logic [CIDX_W-1:0] {
    REG_SET_COUNT   = 2'd0,
    REG_RANGE_START = 2'd1,
    REG_RANGE_END   = 2'd2
  } cfg_reg_t;

  // Everything the back end needs about one finished load, except the conflict matrix.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CODE_W-1:0]  range_start;
    logic [CODE_W-1:0]  range_end;
  } job_hdr_t;

endpackage

[src/esp_if.sv]
// Valid/ready channel interfaces for set masks in and packing results out.
interface esp_set_if import esp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] set_mask;

  modport source (output valid, output set_mask, input ready);
  modport sink   (input valid, input set_mask, output ready);
endinterface

interface esp_result_if import esp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_packing;

  modport source (output valid, output best_packing, input ready);
  modport sink   (input valid, input best_packing, output ready);
endinterface

[src/esp_front.sv]
// Load side: stores set masks, builds the pairwise conflict matrix, emits a job per load.
module esp_front import esp_pkg::*; #(
  parameter int MAX_SETS     = 16,
  parameter int ELEMENT_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  esp_set_if.sink                      set_in,
  input  logic [COUNT_W-1:0]           set_count,
  input  logic [CODE_W-1:0]            range_start,
  input  logic [CODE_W-1:0]            range_end,
  input  logic                         q_full,
  output logic                         push,
  output job_hdr_t                     job_hdr,
  output logic [MAX_SETS*MAX_SETS-1:0] job_clash
);

  localparam int LOAD_W = $clog2(MAX_SETS + 1);
  localparam int IDX_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  logic [LOAD_W-1:0]       sets_loaded;
  logic [ELEMENT_BITS-1:0] set_store [MAX_SETS];
  logic [MAX_SETS-1:0]     clash [MAX_SETS];
  logic [MAX_SETS-1:0]     clash_next [MAX_SETS];

  logic [ELEMENT_BITS-1:0] mask_m;
  logic [COUNT_W-1:0]      eff_count;
  logic [IDX_W-1:0]        wr_idx;
  logic [LOAD_W-1:0]       loaded_inc;
  logic                    load_done;
  logic                    accept;
  logic [MAX_SETS-1:0]     overlap;

  assign set_in.ready = !q_full;
  assign accept       = set_in.valid && set_in.ready;
  assign mask_m       = set_in.set_mask[ELEMENT_BITS-1:0];

  always_comb begin
    priority if (set_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (set_count > COUNT_W'(MAX_SETS)) begin
      eff_count = COUNT_W'(MAX_SETS);
    end else begin
      eff_count = set_count;
    end
  end

  // sets_loaded never passes MAX_SETS; the guard mirrors the wrap of the store index
  assign wr_idx     = (sets_loaded >= LOAD_W'(MAX_SETS)) ? '0 : sets_loaded[IDX_W-1:0];
  assign loaded_inc = LOAD_W'(wr_idx) + LOAD_W'(1);
  assign load_done  = COUNT_W'(loaded_inc) >= eff_count;

  // new set against every earlier set of this load
  always_comb begin
    for (int i = 0; i < MAX_SETS; i++) begin
      overlap[i] = (IDX_W'(i) < wr_idx) && (|(mask_m & set_store[i]));
    end
  end

  // matrix stays symmetric: row of the new set plus its column in the other rows
  always_comb begin
    for (int r = 0; r < MAX_SETS; r++) begin
      clash_next[r] = clash[r];
      if (IDX_W'(r) == wr_idx) begin
        clash_next[r] = overlap;
      end else begin
        clash_next[r][wr_idx] = overlap[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_SETS; r++) begin
      job_clash[r*MAX_SETS +: MAX_SETS] = clash_next[r];
    end
  end

  assign push                = accept && load_done;
  assign job_hdr.count       = eff_count;
  assign job_hdr.range_start = range_start;
  assign job_hdr.range_end   = range_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sets_loaded <= '0;
    end else if (accept) begin
      sets_loaded <= load_done ? '0 : loaded_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_store[wr_idx] <= mask_m;
      for (int r = 0; r < MAX_SETS; r++) begin
        clash[r] <= clash_next[r];
      end
    end
  end

endmodule

[src/esp_queue.sv]
// Two-entry job queue between the load side and the enumerator.
module esp_queue import esp_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[src/esp_back.sv]
// Enumerator: walks the subset codes of one job, one code a cycle, and registers the result.
module esp_back import esp_pkg::*; #(
  parameter int MAX_SETS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  job_hdr_t                     job_hdr,
  input  logic [MAX_SETS*MAX_SETS-1:0] job_clash,
  output logic                         pop,
  esp_result_if.source                 result_out
);

  logic                busy;
  logic [CODE_W-1:0]   code;
  logic [CODE_W-1:0]   code_end;
  logic [COUNT_W-1:0]  count_r;
  logic [MAX_SETS-1:0] clash_r [MAX_SETS];
  logic [BEST_W-1:0]   best;
  logic                out_valid;
  logic [BEST_W-1:0]   out_best;

  logic [MAX_SETS-1:0] chosen;
  logic                conflict;
  logic [BEST_W-1:0]   chosen_cnt;
  logic                running;
  logic                finish;

  // only the low count bits of the code pick sets
  always_comb begin
    for (int i = 0; i < MAX_SETS; i++) begin
      chosen[i] = (COUNT_W'(i) < count_r) && ((i < CODE_W) ? code[i % CODE_W] : 1'b0);
    end
  end

  always_comb begin
    conflict   = 1'b0;
    chosen_cnt = '0;
    for (int i = 0; i < MAX_SETS; i++) begin
      conflict   = conflict | (chosen[i] & (|(clash_r[i] & chosen)));
      chosen_cnt = chosen_cnt + BEST_W'(chosen[i]);
    end
  end

  assign running = busy && (code < code_end);
  assign pop     = !busy && !q_empty;
  assign finish  = busy && !running && (!out_valid || result_out.ready);

  assign result_out.valid        = out_valid;
  assign result_out.best_packing = out_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code     <= job_hdr.range_start;
      code_end <= job_hdr.range_end;
      count_r  <= job_hdr.count;
      best     <= '0;
      for (int r = 0; r < MAX_SETS; r++) begin
        clash_r[r] <= job_clash[r*MAX_SETS +: MAX_SETS];
      end
    end else if (running) begin
      code <= code + CODE_W'(1);
      if (!conflict && (chosen_cnt > best)) begin
        best <= chosen_cnt;
      end
    end
    if (finish) begin
      out_best <= best;
    end
  end

`ifndef NO_ASSERTIONS
  a_code_steps: assert property (@(posedge clk) disable iff (rst)
    running |=> (code == $past(code) + CODE_W'(1)))
    else $error("subset code did not advance by one");

  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> (best >= $past(best)))
    else $error("running best decreased within a job");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    busy |-> (best <= BEST_W'(count_r)))
    else $error("running best exceeds the set count of the job");

  a_result_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_best <= BEST_W'(MAX_SETS)))
    else $error("result exceeds the number of sets");
`endif

endmodule

[src/exhaustive_set_packing_core.sv]
// Top level of the exhaustive maximum set packing core.
// Sets arrive one per transaction on set_in at one per cycle while set_in is ready; the
// load side stores each mask and updates a pairwise conflict matrix as it lands. The
// transaction that completes a load hands a job (count, range, conflict matrix) into a
// two-entry queue. The enumerator then checks one subset code per cycle: it takes the
// job from the queue, checks each code of the range in turn, and then posts the result
// into the output register; an empty range posts a result of 0 without checking any
// code, since the running best is cleared when the job is taken from the queue. Posting
// waits while the output register still holds a result that result_out has not taken.
// The enumerator loop sets the throughput; the queue lets the next load stream in while
// the current one is being enumerated, and set_in stalls only when two finished loads are
// waiting. Configuration writes apply immediately: set_count is read on every set
// transaction, the range is captured when a load completes.
module exhaustive_set_packing_core import esp_pkg::*; #(
  parameter int MAX_SETS     = 16,
  parameter int ELEMENT_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  esp_set_if.sink           set_in,
  esp_result_if.source      result_out
);

  localparam int CLASH_W = MAX_SETS * MAX_SETS;
  localparam int JOB_W   = $bits(job_hdr_t) + CLASH_W;

  // configuration registers
  logic [COUNT_W-1:0] set_count;
  logic [CODE_W-1:0]  range_start;
  logic [CODE_W-1:0]  range_end;

  // front to queue
  logic               push;
  logic               q_full;
  job_hdr_t           front_hdr;
  logic [CLASH_W-1:0] front_clash;

  // queue to back
  logic               pop;
  logic               q_empty;
  logic [JOB_W-1:0]   q_data;
  job_hdr_t           back_hdr;
  logic [CLASH_W-1:0] back_clash;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_count   <= COUNT_W'(16);
      range_start <= '0;
      range_end   <= CODE_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_COUNT:   set_count   <= cfg_data[COUNT_W-1:0];
        REG_RANGE_START: range_start <= cfg_data[CODE_W-1:0];
        REG_RANGE_END:   range_end   <= cfg_data[CODE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  esp_front #(
    .MAX_SETS     (MAX_SETS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .set_in      (set_in),
    .set_count   (set_count),
    .range_start (range_start),
    .range_end   (range_end),
    .q_full      (q_full),
    .push        (push),
    .job_hdr     (front_hdr),
    .job_clash   (front_clash)
  );

  esp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({front_hdr, front_clash}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign back_hdr   = q_data[JOB_W-1:CLASH_W];
  assign back_clash = q_data[CLASH_W-1:0];

  esp_back #(
    .MAX_SETS (MAX_SETS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .job_hdr    (back_hdr),
    .job_clash  (back_clash),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

[tb/tb_exhaustive_set_packing_core.sv]
// Self-checking testbench for the exhaustive maximum set packing core.
`timescale 1ns / 1ps

module tb_exhaustive_set_packing_core;
  import esp_pkg::*;

  localparam int MAX_SETS      = 16;
  localparam int CODE_MAX      = (1 << CODE_W) - 1;
  localparam int SETTLE_CYCLES = 16;         // settle time for the load side after the sender pauses
  localparam int ITEMS_PER_MODE = 430;       // four idle modes plus directed, about 1900 sets
  localparam int CYCLE_LIMIT   = 3_000_000;  // watchdog limit on the whole run

  // ---------------------------------------------------------------------------
  // Clock, reset and the plain config port. Everything has a known value at t=0.
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_SET_COUNT;
  logic [CFG_W-1:0]  cfg_data = '0;

  esp_set_if    set_if ();
  esp_result_if res_if ();

  exhaustive_set_packing_core #(
    .MAX_SETS     (MAX_SETS),
    .ELEMENT_BITS (MASK_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .set_in     (set_if),
    .result_out (res_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stimulus queue, expected packings and run statistics
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0] mask_queue[$];         // sets waiting to be offered
  logic [BEST_W-1:0] expected_packings[$];  // predicted best_packing, oldest first

  int unsigned src_idle_pct  = 0;   // chance per cycle the sender holds back
  int unsigned snk_stall_pct = 0;   // chance per cycle the receiver drops ready
  int unsigned hold_req_id   = 0;   // bump to ask the ready process for a long holdoff
  int unsigned hold_req_len  = 0;

  int unsigned fail_count      = 0;
  int unsigned sets_pushed     = 0;
  int unsigned sets_taken      = 0;
  int unsigned loads_done      = 0;
  int unsigned results_checked = 0;
  int unsigned best_seen       = 0;
  int unsigned settings_used   = 0;
  int unsigned empty_ranges    = 0;
  int unsigned cycle_count     = 0;

  bit set_taken = 1'b0;  // transaction on set_in at the last rising edge

  // ---------------------------------------------------------------------------
  // Predictor state: shadow of the set store, load progress and the registers.
  // Register shadows follow the block's reset values.
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0]  shadow_sets[MAX_SETS];
  int unsigned        sets_held = 0;
  logic [COUNT_W-1:0] count_reg = COUNT_W'(16);
  logic [CODE_W-1:0]  start_reg = '0;
  logic [CODE_W-1:0]  end_reg   = CODE_W'(65536);

  // 0 acts as one set, anything past MAX_SETS as MAX_SETS.
  function automatic int unsigned live_count(logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_SETS) return MAX_SETS;
    return c;
  endfunction

  // Walk every code in [lo, hi); only the low n bits pick sets, so codes past 2^n
  // revisit earlier subsets. A subset counts when no element is claimed twice.
  function automatic logic [BEST_W-1:0] best_packing_of(int unsigned n,
                                                         logic [CODE_W-1:0] lo,
                                                         logic [CODE_W-1:0] hi);
    int unsigned       best;
    int unsigned       code;
    int unsigned       chosen;
    int unsigned       picked;
    logic [MASK_W-1:0] claimed;
    bit                clash;
    best = 0;
    for (code = lo; code < hi; code++) begin
      chosen  = code & ((1 << n) - 1);
      claimed = '0;
      clash   = 1'b0;
      picked  = 0;
      for (int i = 0; i < n; i++) begin
        if (chosen[i]) begin
          if ((claimed & shadow_sets[i]) != 0) clash = 1'b1;
          claimed |= shadow_sets[i];
          picked++;
        end
      end
      if (!clash && picked > best) best = picked;
    end
    return best[BEST_W-1:0];
  endfunction

  // Mostly sparse masks drawn from a window of elements shared by one load, so the
  // packings land anywhere from 1 to n; some empty, dense and all-ones masks mixed in.
  function automatic logic [MASK_W-1:0] random_mask(int unsigned span, int unsigned base);
    logic [MASK_W-1:0] m;
    int unsigned       kind;
    m    = '0;
    kind = $urandom_range(99);
    if (kind < 8) begin
      m = '0;
    end else if (kind < 14) begin
      m = {$urandom, $urandom};
    end else if (kind < 16) begin
      m = '1;
    end else begin
      repeat ($urandom_range(3, 1)) m[(base + $urandom_range(span - 1)) % MASK_W] = 1'b1;
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued set at the falling edge, holds it until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      set_if.valid    <= 1'b0;
      set_if.set_mask <= '0;
    end else if (set_if.valid && !set_taken) begin
      // still waiting for ready, keep the transaction stable
    end else if (mask_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      set_if.valid    <= 1'b1;
      set_if.set_mask <= mask_queue.pop_front();
    end else begin
      // idle cycle: junk on the payload must be ignored
      set_if.valid    <= 1'b0;
      set_if.set_mask <= {$urandom, $urandom};
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready. Random stalls per phase, plus a long holdoff counted here
  // whenever the stimulus side asks for one.
  // ---------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (hold_req_id != hold_seen) begin
      hold_seen = hold_req_id;
      hold_left = hold_req_len;
    end
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Input monitor + predictor. Every accepted set goes into the shadow store;
  // the one that completes a load produces an expected packing.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : take_set
    int unsigned n;
    set_taken = 1'b0;
    if (!rst && set_if.valid && set_if.ready) begin
      set_taken = 1'b1;
      sets_taken++;
      n = live_count(count_reg);
      if (sets_held >= MAX_SETS) sets_held = 0;
      shadow_sets[sets_held] = set_if.set_mask;
      sets_held++;
      // A count lowered mid-load is already met here: this set closes the load.
      if (sets_held >= n) begin
        sets_held = 0;
        expected_packings.push_back(best_packing_of(n, start_reg, end_reg));
        loads_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: each result transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_packing
    logic [BEST_W-1:0] want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_packings.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual best_packing %0d",
                 $time, res_if.best_packing);
      end else begin
        want = expected_packings.pop_front();
        results_checked++;
        if (res_if.best_packing !== want) begin
          fail_count++;
          $display("%0t: best_packing mismatch, expected %0d, actual %0d",
                   $time, want, res_if.best_packing);
        end
        if (want > best_seen) best_seen = want;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still expected",
               $time, cycle_count, expected_packings.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Config write, only issued while the block is quiet. The shadow is updated
  // together with the write since no set can land in between.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_SET_COUNT: begin
        count_reg = d[COUNT_W-1:0];
      end
      REG_RANGE_START: begin
        start_reg = d[CODE_W-1:0];
      end
      REG_RANGE_END: begin
        end_reg = d[CODE_W-1:0];
        settings_used++;
        if (start_reg >= end_reg) empty_ranges++;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_setting(logic [CFG_W-1:0] cnt, int unsigned lo, int unsigned hi);
    write_reg(REG_SET_COUNT, cnt);
    write_reg(REG_RANGE_START, CFG_W'(lo));
    write_reg(REG_RANGE_END, CFG_W'(hi));
  endtask

  task automatic push_mask(logic [MASK_W-1:0] m);
    mask_queue.push_back(m);
    sets_pushed++;
  endtask

  task automatic push_load(int unsigned n);
    int unsigned span;
    int unsigned base;
    span = $urandom_range(4 * n, n);
    if (span > MASK_W) span = MASK_W;
    base = $urandom_range(MASK_W - 1);
    repeat (n) push_mask(random_mask(span, base));
  endtask

  // Sender pause: everything offered, every result back, then a short settle.
  // Checked at the rising edge, where the driver's outputs are stable.
  task automatic wait_quiet();
    do @(posedge clk);
    while (mask_queue.size() != 0 || set_if.valid || expected_packings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random register setting followed by a batch of loads under it.
  task automatic random_setting();
    logic [COUNT_W-1:0] c;
    logic [CFG_W-1:0]   d;
    int unsigned        n;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 4)       c = '0;
    else if (pick < 8)  c = COUNT_W'($urandom_range(31, MAX_SETS + 1));
    else if (pick < 70) c = COUNT_W'($urandom_range(8, 1));
    else                c = COUNT_W'($urandom_range(MAX_SETS, 9));
    n = live_count(c);

    // Ranges: empty, every subset of a small load, or a short window anywhere in
    // the 17-bit code space (windows past 2^n revisit subsets).
    pick = $urandom_range(99);
    if (pick < 10) begin
      lo = $urandom_range(CODE_MAX);
      hi = $urandom_range(lo);
    end else if (pick < 55 && n <= 8) begin
      lo = 0;
      hi = 1 << n;
    end else begin
      lo = $urandom_range(CODE_MAX);
      hi = lo + $urandom_range(256, 1);
      if (hi > CODE_MAX) hi = CODE_MAX;
    end

    // Upper data bits are junk for the count register.
    d = CFG_W'($urandom);
    d[COUNT_W-1:0] = c;
    write_setting(d, lo, hi);

    repeat ((60 + n - 1) / n) push_load(n);
    // Now and then leave a load half done; the next setting picks it up.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(n - 1)) push_mask(random_mask(MASK_W, 0));
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int unsigned src_pct[4] = '{0, 50, 0, 14};
  int unsigned snk_pct[4] = '{0, 0, 50, 14};

  initial begin
    int unsigned mark;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- Directed ---------------------------------------------------------
    // Reset settings: 16 sets, the whole 2^16 code range. Mask extremes: empty,
    // all ones, lone top and bottom bits, and nibble sets that clash with them.
    push_mask('0);
    push_mask('1);
    push_mask({1'b1, {(MASK_W - 2){1'b0}}, 1'b1});
    push_mask(MASK_W'(1));
    push_mask({1'b1, {(MASK_W - 1){1'b0}}});
    for (int i = 5; i < MAX_SETS; i++) push_mask(MASK_W'(64'hF) << (4 * i));
    wait_quiet();

    // Count of zero acts as one set.
    write_setting('0, 0, 2);
    push_mask('1);
    wait_quiet();

    // Empty range with start equal to end, then start above end at the code limit.
    write_setting(CFG_W'(2), 5, 5);
    push_mask(MASK_W'(1));
    push_mask(MASK_W'(2));
    wait_quiet();
    write_setting(CFG_W'(1), CODE_MAX, 0);
    push_mask(MASK_W'(4));
    wait_quiet();

    // Window at the very top of the code space.
    write_setting(CFG_W'(3), CODE_MAX - 255, CODE_MAX);
    push_mask(MASK_W'(1));
    push_mask(MASK_W'(2));
    push_mask(MASK_W'(3));
    wait_quiet();

    // Count lowered mid-load: three of four sets in, count drops to two, and the
    // next set closes the load using the first two stored entries.
    write_setting(CFG_W'(4), 0, 16);
    push_mask(MASK_W'(1));
    push_mask(MASK_W'(2));
    push_mask(MASK_W'(1));
    wait_quiet();
    write_reg(REG_SET_COUNT, CFG_W'(2));
    push_mask(MASK_W'(8));
    wait_quiet();

    // --- Backpressure -----------------------------------------------------
    // Small loads with tiny ranges and a long receiver holdoff: the job queue and
    // output register fill and set_in has to stall.
    write_setting(CFG_W'(2), 0, 4);
    repeat (40) push_load(2);
    hold_req_len = 500;
    hold_req_id++;
    wait_quiet();

    // --- Random, one block per idle mode ----------------------------------
    for (int mode = 0; mode < 4; mode++) begin
      src_idle_pct  = src_pct[mode];
      snk_stall_pct = snk_pct[mode];
      mark = sets_pushed;
      while (sets_pushed - mark < ITEMS_PER_MODE) random_setting();
    end
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    wait_quiet();

    if (expected_packings.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_packings.size());
    end

    $display("summary: %0d sets accepted in %0d loads, %0d packings checked (largest %0d)",
             sets_taken, loads_done, results_checked, best_seen);
    $display("summary: %0d register settings, %0d with an empty code range, %0d cycles",
             settings_used, empty_ranges, cycle_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[exhaustive_set_packing_core.f]
src/esp_pkg.sv
src/esp_if.sv
src/esp_front.sv
src/esp_queue.sv
src/esp_back.sv
src/exhaustive_set_packing_core.sv
tb/tb_exhaustive_set_packing_core.sv
